FILE: rtl/core/tama_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tama_pkg
// Shared constants and types for the three-axis moving-average filter.
// ----------------------------------------------------------------------------
package tama_pkg;

  localparam int TAPS         = 8;
  localparam int SAMPLE_WIDTH = 16;
  localparam int NAX          = 3;
  localparam int SUM_W        = SAMPLE_WIDTH + $clog2(TAPS) + 1;
  localparam int CNT_W        = $clog2(TAPS + 1);
  localparam int POS_W        = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int STEP_W       = $clog2(SUM_W);

  typedef struct packed {
    logic                           restart;
    logic signed [SAMPLE_WIDTH-1:0] accel_x;
    logic signed [SAMPLE_WIDTH-1:0] accel_y;
    logic signed [SAMPLE_WIDTH-1:0] accel_z;
  } tama_in_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] avg_x;
    logic signed [SAMPLE_WIDTH-1:0] avg_y;
    logic signed [SAMPLE_WIDTH-1:0] avg_z;
  } tama_out_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic step;
    logic ld_out;
  } tama_cmd_t;

  typedef struct packed {
    logic last_step;
  } tama_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } tama_state_t;

endpackage
`default_nettype wire

FILE: rtl/core/tama_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tama_ctrl
// Sequencer: update, divider setup, divide steps, result hand-off.
// ----------------------------------------------------------------------------
module tama_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 sample_valid,
  output logic                      sample_stall,
  output logic                      avg_valid,
  input  wire logic                 avg_stall,
  output tama_pkg::tama_cmd_t       cmd,
  input  wire tama_pkg::tama_stat_t stat
);
  import tama_pkg::*;

  tama_state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (stat.last_step) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!avg_valid || !avg_stall) begin
          cmd.ld_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign sample_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      avg_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.ld_out) begin
        avg_valid <= 1'b1;
      end else if (!avg_stall) begin
        avg_valid <= 1'b0;
      end
    end
  end

  a_load_then_prep: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ST_PREP)
    else $error("load not followed by divider setup");

  a_valid_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(avg_valid) |-> $past(state == ST_DONE))
    else $error("result raised outside hand-off");

  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) && stat.last_step |=> state == ST_DONE)
    else $error("divide did not end after last step");

endmodule
`default_nettype wire

FILE: rtl/core/tama_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tama_dp
// Sample rings, running sums, fill count and three bit-serial dividers.
// ----------------------------------------------------------------------------
module tama_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tama_pkg::tama_in_t  smp_in,
  input  wire tama_pkg::tama_cmd_t cmd,
  output tama_pkg::tama_stat_t     stat,
  output tama_pkg::tama_out_t      avg
);
  import tama_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] ring [NAX][TAPS];
  logic        [TAPS-1:0]         vld, vld_next;
  logic signed [SUM_W-1:0]        sum      [NAX];
  logic signed [SUM_W-1:0]        sum_next [NAX];
  logic        [CNT_W-1:0]        cnt, cnt_next;
  logic        [POS_W-1:0]        wpos, wpos_next;
  logic        [POS_W-1:0]        eff_pos;

  logic signed [SAMPLE_WIDTH-1:0] smp  [NAX];
  logic signed [SAMPLE_WIDTH-1:0] old  [NAX];
  logic signed [SUM_W-1:0]        base [NAX];

  logic [SUM_W-1:0]        q    [NAX];
  logic [CNT_W-1:0]        rem  [NAX];
  logic                    neg  [NAX];
  logic [CNT_W:0]          trial[NAX];
  logic [SAMPLE_WIDTH-1:0] res  [NAX];
  logic [STEP_W-1:0]       step;

  assign smp[0] = smp_in.accel_x;
  assign smp[1] = smp_in.accel_y;
  assign smp[2] = smp_in.accel_z;

  always_comb begin
    eff_pos = smp_in.restart ? '0 : wpos;
    for (int a = 0; a < NAX; a++) begin
      old[a]      = (smp_in.restart || !vld[eff_pos]) ? '0 : ring[a][eff_pos];
      base[a]     = smp_in.restart ? '0 : sum[a];
      sum_next[a] = base[a] - SUM_W'(old[a]) + SUM_W'(smp[a]);
    end
    vld_next  = (smp_in.restart ? '0 : vld) | (TAPS'(1) << eff_pos);
    if (smp_in.restart) begin
      cnt_next = CNT_W'(1);
    end else if (cnt < CNT_W'(TAPS)) begin
      cnt_next = cnt + CNT_W'(1);
    end else begin
      cnt_next = cnt;
    end
    wpos_next = (eff_pos == POS_W'(TAPS - 1)) ? '0 : eff_pos + POS_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      cnt  <= '0;
      wpos <= '0;
      for (int a = 0; a < NAX; a++) begin
        sum[a] <= '0;
      end
    end else if (cmd.load) begin
      vld  <= vld_next;
      cnt  <= cnt_next;
      wpos <= wpos_next;
      for (int a = 0; a < NAX; a++) begin
        sum[a] <= sum_next[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int a = 0; a < NAX; a++) begin
        ring[a][eff_pos] <= smp[a];
      end
    end
  end

  // restoring divide of |sum| by fill count, one quotient bit per cycle
  always_comb begin
    for (int a = 0; a < NAX; a++) begin
      trial[a] = {rem[a], q[a][SUM_W-1]};
      res[a]   = neg[a] ? -q[a][SAMPLE_WIDTH-1:0] : q[a][SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      step <= STEP_W'(SUM_W - 1);
      for (int a = 0; a < NAX; a++) begin
        neg[a] <= sum[a][SUM_W-1];
        q[a]   <= sum[a][SUM_W-1] ? -sum[a] : sum[a];
        rem[a] <= '0;
      end
    end else if (cmd.step) begin
      step <= step - STEP_W'(1);
      for (int a = 0; a < NAX; a++) begin
        if (trial[a] >= {1'b0, cnt}) begin
          rem[a] <= CNT_W'(trial[a] - {1'b0, cnt});
          q[a]   <= {q[a][SUM_W-2:0], 1'b1};
        end else begin
          rem[a] <= trial[a][CNT_W-1:0];
          q[a]   <= {q[a][SUM_W-2:0], 1'b0};
        end
      end
    end
  end

  assign stat.last_step = (step == '0);

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      avg.avg_x <= res[0];
      avg.avg_y <= res[1];
      avg.avg_z <= res[2];
    end
  end

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.prep |-> cnt != '0)
    else $error("divide started with zero fill count");

  a_count_capped: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(TAPS))
    else $error("fill count above tap count");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.load && smp_in.restart |=> cnt == CNT_W'(1) && vld == TAPS'(1))
    else $error("restart did not leave a single entry");

endmodule
`default_nettype wire

FILE: rtl/core/three_axis_moving_average.sv
`default_nettype none
// ----------------------------------------------------------------------------
// three_axis_moving_average
// Eight-tap boxcar average of X, Y and Z acceleration samples.
//
//   channel  handshake                    payload
//   sample   sample_valid / sample_stall  tama_in_t  (restart, accel_x/y/z)
//   avg      avg_valid / avg_stall        tama_out_t (avg_x/y/z)
//
// Each item goes through the ring and sum update, the divider load, SUM_W
// divide steps and the hand-off; the bit-serial dividers divide the sums of
// the 16-bit samples by the fill count. A new sample waits for the hand-off.
// The result register lets the next item start while a result waits.
// Reset empties the rings at once through per-entry valid bits.
// ----------------------------------------------------------------------------
module three_axis_moving_average (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                sample_valid,
  output logic                     sample_stall,
  input  wire tama_pkg::tama_in_t  sample,
  output logic                     avg_valid,
  input  wire logic                avg_stall,
  output tama_pkg::tama_out_t      avg
);
  import tama_pkg::*;

  tama_cmd_t  cmd;
  tama_stat_t stat;

  tama_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .avg_valid    (avg_valid),
    .avg_stall    (avg_stall),
    .cmd          (cmd),
    .stat         (stat)
  );

  tama_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .smp_in (sample),
    .cmd    (cmd),
    .stat   (stat),
    .avg    (avg)
  );

endmodule
`default_nettype wire

FILE: verif/three_axis_moving_average_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// three_axis_moving_average_test
// Self-checking bench for the three-axis eight-tap boxcar filter.
// A scoreboard keeps its own rings, sums and fill count, predicts each average
// as it sees a sample go in, and checks every average that comes out. The run
// starts with directed samples: extremes, ring fill and wrap, restarts and
// truncation toward zero. Random samples follow under four handshake
// pressure phases, including a long output hold-off and a full drain.
// ----------------------------------------------------------------------------
module three_axis_moving_average_test;
  import tama_pkg::*;

  localparam int LATENCY    = SUM_W + 3;
  localparam int QUIET_MAX  = 2000;
  localparam int HOLD_LEN   = 300;
  localparam int PHASE_LEN  = 320;

  class avg_scoreboard;
    tama_out_t                      expected_avgs[$];
    logic signed [SAMPLE_WIDTH-1:0] ring[NAX][TAPS];
    longint                         sums[NAX];
    int                             wr_pos;
    int                             fill;
    int                             errors;
    int                             checked;
    int                             restarts;

    function void clear_store();
      foreach (ring[a, t]) ring[a][t] = '0;
      foreach (sums[a]) sums[a] = 0;
      wr_pos = 0;
      fill = 0;
    endfunction

    function int pending();
      return expected_avgs.size();
    endfunction

    function void note_sample(tama_in_t s);
      logic signed [SAMPLE_WIDTH-1:0] smp[NAX];
      longint                         q[NAX];
      tama_out_t                      e;
      smp[0] = s.accel_x;
      smp[1] = s.accel_y;
      smp[2] = s.accel_z;
      if (s.restart) begin
        clear_store();
        restarts++;
      end
      for (int a = 0; a < NAX; a++) begin
        sums[a] = sums[a] - ring[a][wr_pos] + smp[a];
        ring[a][wr_pos] = smp[a];
      end
      if (fill < TAPS) fill++;
      wr_pos = (wr_pos + 1) % TAPS;
      // signed division truncates toward zero
      for (int a = 0; a < NAX; a++) q[a] = sums[a] / fill;
      e.avg_x = q[0][SAMPLE_WIDTH-1:0];
      e.avg_y = q[1][SAMPLE_WIDTH-1:0];
      e.avg_z = q[2][SAMPLE_WIDTH-1:0];
      expected_avgs.push_back(e);
    endfunction

    function void check_avg(tama_out_t got);
      tama_out_t e;
      if (expected_avgs.size() == 0) begin
        errors++;
        $display("%0t: unexpected avg item x=%0d y=%0d z=%0d",
                 $time, got.avg_x, got.avg_y, got.avg_z);
        return;
      end
      e = expected_avgs.pop_front();
      checked++;
      if (got.avg_x !== e.avg_x) begin
        errors++;
        $display("%0t: avg_x expected %0d actual %0d", $time, e.avg_x, got.avg_x);
      end
      if (got.avg_y !== e.avg_y) begin
        errors++;
        $display("%0t: avg_y expected %0d actual %0d", $time, e.avg_y, got.avg_y);
      end
      if (got.avg_z !== e.avg_z) begin
        errors++;
        $display("%0t: avg_z expected %0d actual %0d", $time, e.avg_z, got.avg_z);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst;
  logic      sample_valid;
  logic      sample_stall;
  tama_in_t  sample;
  logic      avg_valid;
  logic      avg_stall;
  tama_out_t avg;

  avg_scoreboard sb = new();
  int            src_idle_pct = 0;
  int            snk_stall_pct = 0;
  int            hold_cycles = 0;
  int            sent = 0;
  int            quiet = 0;

  three_axis_moving_average u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .avg_valid    (avg_valid),
    .avg_stall    (avg_stall),
    .avg          (avg)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // monitor: values read here are the ones settled before this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (sample_valid && !sample_stall) sb.note_sample(sample);
      if (avg_valid && !avg_stall) sb.check_avg(avg);
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (avg_valid && !avg_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_MAX) begin
      $display("%0t: no handshake for %0d cycles, %0d averages outstanding",
               $time, QUIET_MAX, sb.pending());
      $display("three_axis_moving_average_test: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : avg_sink
    int hold_n;
    avg_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_n = hold_cycles;
        hold_cycles = 0;
        avg_stall <= 1'b1;
        repeat (hold_n) @(posedge clk);
      end else begin
        avg_stall <= ($urandom_range(99) < snk_stall_pct);
      end
    end
  end

  function automatic tama_in_t make_sample(bit restart, int x, int y, int z);
    tama_in_t s;
    s.restart = restart;
    s.accel_x = x[SAMPLE_WIDTH-1:0];
    s.accel_y = y[SAMPLE_WIDTH-1:0];
    s.accel_z = z[SAMPLE_WIDTH-1:0];
    return s;
  endfunction

  function automatic int rand_axis();
    case ($urandom_range(9))
      0: return 32767;
      1: return -32768;
      2, 3: return int'($urandom_range(40)) - 20;
      4: return 1000 + int'($urandom_range(200)) - 100;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  task automatic send_sample(input tama_in_t s);
    while ($urandom_range(99) < src_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (sample_stall);
    sent++;
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() > 0);
  endtask

  initial begin : stimulus
    int idle_set[4];
    int stall_set[4];
    idle_set  = '{0, 82, 0, 24};
    stall_set = '{0, 0, 82, 24};
    sb.clear_store();
    rst <= 1'b1;
    sample_valid <= 1'b0;
    sample <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // first samples after reset, then fill and wrap the ring at the extremes
    send_sample(make_sample(1'b0, 32767, -32768, 0));
    for (int i = 0; i < 9; i++) send_sample(make_sample(1'b0, 32767, -32768, -1));
    send_sample(make_sample(1'b0, -32768, 32767, 1));
    // restart mid-stream and restart on a fresh store
    send_sample(make_sample(1'b1, -32768, 32767, 1));
    send_sample(make_sample(1'b1, 5, -5, 0));
    // small sums that must truncate toward zero
    send_sample(make_sample(1'b0, -6, 6, 1));
    send_sample(make_sample(1'b0, 0, 0, -2));
    send_sample(make_sample(1'b1, -1, 1, -3));
    send_sample(make_sample(1'b0, 0, 0, 1));
    send_sample(make_sample(1'b0, -1, 2, 0));
    send_sample(make_sample(1'b0, 1, -1, -1));
    drain();

    for (int p = 0; p < 4; p++) begin
      src_idle_pct = idle_set[p];
      snk_stall_pct = stall_set[p];
      for (int i = 0; i < PHASE_LEN; i++) begin
        if (p == 0 && i == PHASE_LEN / 2) hold_cycles = HOLD_LEN;
        send_sample(make_sample($urandom_range(99) < 3, rand_axis(), rand_axis(),
                                rand_axis()));
      end
      drain();
    end

    src_idle_pct = 0;
    snk_stall_pct = 0;
    repeat (LATENCY + 8) @(posedge clk);
    if (sb.pending() > 0) begin
      sb.errors++;
      $display("%0t: %0d expected averages never arrived", $time, sb.pending());
    end
    $display("Sent %0d samples (%0d restarts) under four idle/stall mixes and a %0d-cycle hold-off.",
             sent, sb.restarts, HOLD_LEN);
    $display("Checked %0d averages, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("three_axis_moving_average_test: PASS");
    end else begin
      $display("three_axis_moving_average_test: FAIL");
    end
    $finish;
  end

endmodule
